@@ hdl/pss_pkg.sv @@
// Shared types and constants of the printable string scanner.
// Used by the controller, the datapath and the top level; depends on nothing.
package pss_pkg;

  // Field widths fixed by the item formats
  localparam int MIN_LEN_W  = 6;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITESPACE = 1'd1;

  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd4;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_FLOOR = 6'd2;

  // Zero bytes allowed between two characters
  localparam logic [1:0] MAX_GAP_NULLS = 2'd3;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7e;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_value;
    logic [31:0] start_offset;
    logic        last;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic wr1;     // write second entry of a two-character run
    logic rd;      // read held entry
    logic load;    // load read data into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic can_load;        // output register free or being emptied
    logic need_wr1;        // item starts a two-character run
    logic accept_release;  // item completes a run of minimum length
    logic release_ready;   // held run has reached minimum length
    logic rd_last;         // read index is at the last held entry
  } ctrl_status_t;

endpackage

@@ hdl/pss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/pss_ctrl.sv @@
// Controller of the printable string scanner: sequences input transfers,
// the second hold write and the release sweep. Depends on pss_pkg.
module pss_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  pss_pkg::ctrl_status_t status,
  output pss_pkg::ctrl_cmd_t    cmd,
  output logic                  in_stall
);
  import pss_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR1  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       open;

  assign open     = (state == ST_IDLE) && status.can_load;
  assign in_stall = !open;

  always_comb begin
    cmd.accept = in_valid && open;
    cmd.wr1    = (state == ST_WR1);
    cmd.rd     = (state == ST_RD);
    cmd.load   = (state == ST_LOAD) && status.can_load;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (status.need_wr1) begin
            state_next = ST_WR1;
          end else if (status.accept_release) begin
            state_next = ST_RD;
          end
        end
      end
      ST_WR1: begin
        state_next = status.release_ready ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.can_load) begin
          state_next = status.rd_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/pss_datapath.sv @@
// Datapath of the printable string scanner: configuration, scan state,
// hold buffer RAM and output register. Depends on pss_pkg and pss_ram.
module pss_datapath #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  pss_pkg::in_item_t                   byte_item,
  input  logic                                res_stall,
  output logic                                res_valid,
  output pss_pkg::out_item_t                  res_item,
  input  pss_pkg::ctrl_cmd_t                  cmd,
  output pss_pkg::ctrl_status_t               status
);
  import pss_pkg::*;

  localparam int IDX_W = $clog2(HOLD_DEPTH);
  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

  // Configuration
  logic [MIN_LEN_W-1:0] min_length;
  logic                 ws_printable;

  // Scan state
  logic [31:0]      byte_offset;
  logic [CNT_W-1:0] held_count;
  logic [1:0]       null_run;
  logic [1:0]       exp_gap;
  logic [31:0]      string_start;
  logic [31:0]      last_char_offset;
  logic [7:0]       previous_char;
  logic             emitting;
  logic [7:0]       last_held;
  logic [7:0]       pend_char;
  logic [CNT_W-1:0] rd_idx;

  logic [31:0]      byte_offset_next;
  logic [CNT_W-1:0] held_count_next;
  logic [1:0]       null_run_next;
  logic [1:0]       exp_gap_next;
  logic [31:0]      string_start_next;
  logic [31:0]      last_char_offset_next;
  logic [7:0]       previous_char_next;
  logic             emitting_next;
  logic [7:0]       last_held_next;
  logic [7:0]       pend_char_next;

  logic [7:0]       c;
  logic             printable;
  logic             gap_null;
  logic [CNT_W-1:0] eff_min;
  logic [CNT_W-1:0] count_after;
  logic             first_valid;
  out_item_t        first_item;
  logic             need_wr1;
  logic             accept_release;
  logic             hold_wr;
  logic [IDX_W-1:0] hold_addr;
  logic [7:0]       hold_data;

  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [7:0]       ram_wr_data;
  logic [7:0]       ram_rd_data;

  assign c         = byte_item.data_byte;
  assign printable = ((c >= CHAR_SPACE) && (c <= CHAR_TILDE)) ||
                     ((c == CHAR_TAB) && ws_printable);
  assign gap_null  = (c == CHAR_NUL) && (null_run < MAX_GAP_NULLS);

  // Minimum length clamped to at least MIN_LEN_FLOOR and at most the hold depth
  always_comb begin
    if (min_length < MIN_LEN_FLOOR) begin
      eff_min = CNT_W'(MIN_LEN_FLOOR);
    end else if (32'(min_length) > 32'(HOLD_DEPTH)) begin
      eff_min = CNT_W'(HOLD_DEPTH);
    end else begin
      eff_min = CNT_W'(min_length);
    end
  end

  assign count_after = (held_count < CNT_W'(HOLD_DEPTH)) ? held_count + CNT_W'(1) : held_count;

  // Next scan state for the item at the input
  always_comb begin
    byte_offset_next      = byte_offset;
    held_count_next       = held_count;
    null_run_next         = null_run;
    exp_gap_next          = exp_gap;
    string_start_next     = string_start;
    last_char_offset_next = last_char_offset;
    previous_char_next    = previous_char;
    emitting_next         = emitting;
    last_held_next        = last_held;
    pend_char_next        = pend_char;
    first_valid           = 1'b0;
    first_item.kind         = KIND_END;
    first_item.char_value   = CHAR_NUL;
    first_item.start_offset = string_start;
    first_item.last         = 1'b1;
    need_wr1              = 1'b0;
    accept_release        = 1'b0;
    hold_wr               = 1'b0;
    hold_addr             = '0;
    hold_data             = c;

    if (byte_item.end_marker) begin
      first_valid           = emitting;
      byte_offset_next      = '0;
      held_count_next       = '0;
      null_run_next         = '0;
      exp_gap_next          = '0;
      string_start_next     = '0;
      last_char_offset_next = '0;
      previous_char_next    = '0;
      emitting_next         = 1'b0;
    end else begin
      byte_offset_next = byte_offset + 32'd1;
      if (emitting) begin
        if (gap_null) begin
          null_run_next = null_run + 2'd1;
        end else if (!printable) begin
          first_valid     = 1'b1;
          emitting_next   = 1'b0;
          held_count_next = '0;
          null_run_next   = '0;
          exp_gap_next    = '0;
        end else if (null_run == exp_gap) begin
          first_valid           = 1'b1;
          first_item.kind       = KIND_CHAR;
          first_item.char_value = c;
          previous_char_next    = c;
          last_char_offset_next = byte_offset;
          null_run_next         = '0;
        end else begin
          // Gap changed: close the string and start over
          first_valid           = 1'b1;
          emitting_next         = 1'b0;
          null_run_next         = '0;
          last_char_offset_next = byte_offset;
          last_held_next        = c;
          hold_wr               = 1'b1;
          if (exp_gap != 2'd0) begin
            hold_data         = previous_char;
            need_wr1          = 1'b1;
            pend_char_next    = c;
            held_count_next   = CNT_W'(2);
            string_start_next = last_char_offset;
            exp_gap_next      = null_run;
            accept_release    = (eff_min <= CNT_W'(2));
          end else begin
            held_count_next   = CNT_W'(1);
            string_start_next = byte_offset;
            exp_gap_next      = '0;
          end
          first_item.last = !accept_release;
        end
      end else begin
        if (gap_null) begin
          null_run_next = null_run + 2'd1;
          if (held_count == CNT_W'(1)) begin
            exp_gap_next = exp_gap + 2'd1;
          end
        end else if (!printable) begin
          held_count_next = '0;
          null_run_next   = '0;
          exp_gap_next    = '0;
        end else if (held_count == '0) begin
          null_run_next         = '0;
          exp_gap_next          = '0;
          string_start_next     = byte_offset;
          hold_wr               = 1'b1;
          held_count_next       = CNT_W'(1);
          last_char_offset_next = byte_offset;
          last_held_next        = c;
        end else if (null_run != exp_gap) begin
          // Gap mismatch: last held char and this one form a new run
          hold_wr               = 1'b1;
          hold_data             = last_held;
          need_wr1              = 1'b1;
          pend_char_next        = c;
          held_count_next       = CNT_W'(2);
          string_start_next     = last_char_offset;
          last_char_offset_next = byte_offset;
          exp_gap_next          = null_run;
          null_run_next         = '0;
          last_held_next        = c;
          accept_release        = (eff_min <= CNT_W'(2));
        end else begin
          hold_wr               = (held_count < CNT_W'(HOLD_DEPTH));
          hold_addr             = held_count[IDX_W-1:0];
          held_count_next       = count_after;
          last_char_offset_next = byte_offset;
          null_run_next         = '0;
          last_held_next        = c;
          accept_release        = (count_after >= eff_min);
        end
      end
      if (accept_release) begin
        emitting_next      = 1'b1;
        previous_char_next = c;
      end
    end
  end

  always_comb begin
    status.can_load       = !res_valid || !res_stall;
    status.need_wr1       = need_wr1;
    status.accept_release = accept_release;
    status.release_ready  = (held_count >= eff_min);
    status.rd_last        = ((rd_idx + CNT_W'(1)) == held_count);
  end

  // Hold buffer: entries written on transfer, the second entry of a new two-character run in the follow-up cycle
  assign ram_wr_en   = (cmd.accept && hold_wr) || cmd.wr1;
  assign ram_wr_addr = cmd.wr1 ? IDX_W'(1) : hold_addr;
  assign ram_wr_data = cmd.wr1 ? pend_char : hold_data;

  pss_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length       <= MIN_LEN_RESET;
      ws_printable     <= 1'b0;
      byte_offset      <= '0;
      held_count       <= '0;
      null_run         <= '0;
      exp_gap          <= '0;
      string_start     <= '0;
      last_char_offset <= '0;
      previous_char    <= '0;
      emitting         <= 1'b0;
      rd_idx           <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MIN_LENGTH: min_length   <= cfg_data[MIN_LEN_W-1:0];
          REG_WHITESPACE: ws_printable <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        byte_offset      <= byte_offset_next;
        held_count       <= held_count_next;
        null_run         <= null_run_next;
        exp_gap          <= exp_gap_next;
        string_start     <= string_start_next;
        last_char_offset <= last_char_offset_next;
        previous_char    <= previous_char_next;
        emitting         <= emitting_next;
        rd_idx           <= '0;
      end else if (cmd.load) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if ((cmd.accept && first_valid) || cmd.load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_held <= last_held_next;
      pend_char <= pend_char_next;
    end
    if (cmd.accept && first_valid) begin
      res_item <= first_item;
    end else if (cmd.load) begin
      res_item.kind         <= KIND_CHAR;
      res_item.char_value   <= ram_rd_data;
      res_item.start_offset <= string_start;
      res_item.last         <= status.rd_last;
    end
  end

endmodule

@@ hdl/printable_string_scanner_unit.sv @@
// Printable string scanner, top level: controller plus datapath.
// Depends on pss_pkg, pss_ctrl, pss_datapath and pss_ram.
//
// Usage:
//   Input channel byte_valid/byte_stall/byte_item: one data byte per transfer,
//   or an end marker that closes the current string and restarts the scan.
//   Output channel res_valid/res_stall/res_item: string characters, each with
//   the start offset of its string, and string end results; last marks the
//   final result caused by one input transfer.
//   Config port cfg_write/cfg_index/cfg_data: 0 = min_length, 1 = tab printable.
//   Write it only while the block is idle.
// Timing:
//   A result from a byte is in the output register the cycle after its
//   transfer. A byte that starts a new two-character run also takes an extra
//   step in which the second hold entry is written.
//   A run that reaches the minimum length is released from the hold RAM one
//   held character at a time (registered RAM read, then output load).
//   Input is stalled while the output register is full and stalled, during
//   the second hold write and during a release.
// Reset: rst (synchronous) clears the scan state and restores min_length 4
//   and tab non-printable. Hold RAM contents are not cleared.
module printable_string_scanner_unit #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  pss_pkg::in_item_t              byte_item,
  output logic                           res_valid,
  input  logic                           res_stall,
  output pss_pkg::out_item_t             res_item
);
  import pss_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer: transfer, second hold write, release sweep
  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (byte_stall)
  );

  // Scan state, hold buffer and output register
  pss_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_item (byte_item),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_item  (res_item),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef SYNTH
  // A transfer and a release load never share a cycle
  a_single_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.load))
    else $error("transfer and release load in the same cycle");

  // Second hold write only right after a transfer
  a_wr1_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.wr1 |-> $past(cmd.accept))
    else $error("second hold write without a preceding transfer");

  // Output becomes valid only from a transfer or a release load
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd.accept || cmd.load))
    else $error("result appeared without a source");

  // Final released character carries last
  a_release_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && status.rd_last) |=> (res_valid && res_item.last))
    else $error("final released character lacks last");
`endif

endmodule
